// ===== rtl/core/lase_pkg.sv =====
// Shared types and constants for the local alignment score engine.
// No dependencies; lase_ctrl, lase_dp, the core and lase_checker import it.
`timescale 1ns / 1ps
package lase_pkg;
   localparam int QUERY_MAX  = 256;
   localparam int SCORE_BITS = 16;
   localparam int ROW_BITS   = $clog2(QUERY_MAX);
   localparam int LEN_BITS   = ROW_BITS + 1;
   localparam int CNT_BITS   = 16;
   localparam int SUM_BITS   = SCORE_BITS + 2;

   // item command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_SCORE  = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;  // unused code, reports state only

   // csr register indexes
   localparam logic [1:0] CSR_MATCH    = 2'd0;
   localparam logic [1:0] CSR_MISMATCH = 2'd1;
   localparam logic [1:0] CSR_GAP      = 2'd2;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic append;
      logic col_start;
      logic issue;
      logic finish;
   } lase_cmd_type;

   typedef struct packed {
      logic query_empty;
      logic last_row;
      logic pipe_busy;
   } lase_stat_type;
endpackage

// ===== rtl/core/lase_if.sv =====
// Handshake interfaces for the request and response channels.
// No dependencies; field widths are fixed here.
`timescale 1ns / 1ps
interface lase_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] symbol;
   modport source (output valid, command, symbol, input ready);
   modport sink (input valid, command, symbol, output ready);
endinterface

interface lase_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] best_score;
   logic [15:0] best_column;
   logic [8:0]  best_row;
   logic [15:0] best_tie_count;
   logic [15:0] column_peak;
   logic [8:0]  query_length;
   logic        query_overflow;
   modport source (output valid, best_score, best_column, best_row, best_tie_count,
                   column_peak, query_length, query_overflow, input ready);
   modport sink (input valid, best_score, best_column, best_row, best_tie_count,
                 column_peak, query_length, query_overflow, output ready);
endinterface

// ===== rtl/core/lase_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lase_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data <= mem_ff[read_addr];
   end
endmodule

// ===== rtl/core/lase_ctrl.sv =====
// Controller: item handshake, sequencing of a column scan, response valid.
// Depends on lase_pkg.
`timescale 1ns / 1ps
module lase_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_command,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lase_pkg::lase_cmd_type cmd,
   input  lase_pkg::lase_stat_type stat
);
   import lase_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      fire;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign fire      = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.accept    = fire;
      cmd.clear     = fire && (req_command == CMD_CLEAR);
      cmd.append    = fire && (req_command == CMD_APPEND);
      cmd.col_start = fire && (req_command == CMD_SCORE);
      case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               if (req_command == CMD_SCORE && !stat.query_empty) state_in = ST_SCAN;
               else state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (stat.last_row) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid holds until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end
endmodule

// ===== rtl/core/lase_dp.sv =====
// Datapath: query and column stores, cell pipeline, best-score tracking.
// Depends on lase_pkg and lase_ram.
`timescale 1ns / 1ps
module lase_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  lase_pkg::lase_cmd_type  cmd,
   output lase_pkg::lase_stat_type stat,
   input  logic [7:0]              req_symbol,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_write_data,
   output logic [15:0]             best_score,
   output logic [15:0]             best_column,
   output logic [8:0]              best_row,
   output logic [15:0]             best_tie_count,
   output logic [15:0]             column_peak,
   output logic [8:0]              query_length,
   output logic                    query_overflow
);
   import lase_pkg::*;

   localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
   localparam logic [CNT_BITS-1:0]   CNT_MAX   = '1;

   // configuration
   logic [7:0] match_ff, mismatch_ff, gap_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff    <= 8'd1;
         mismatch_ff <= 8'd1;
         gap_ff      <= 8'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MATCH:    match_ff    <= csr_write_data;
            CSR_MISMATCH: mismatch_ff <= csr_write_data;
            CSR_GAP:      gap_ff      <= csr_write_data;
            default:      ;
         endcase
      end
   end

   // control state
   logic [LEN_BITS-1:0]   len_ff;
   logic [CNT_BITS-1:0]   colcnt_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic                  v1_ff, v2_ff;
   logic [QUERY_MAX-1:0]  cvalid_ff;
   logic [SCORE_BITS-1:0] top_ff, peak_ff;
   logic [CNT_BITS-1:0]   topcol_ff, tie_ff;
   logic [LEN_BITS-1:0]   toprow_ff;
   logic                  ovf_ff;
   // payload
   logic [7:0]            sym_ff;
   logic [ROW_BITS-1:0]   row1_ff, row2_ff;
   logic                  vbit_ff;
   logic [SCORE_BITS-1:0] up_ff, diag_ff, s2_ff;

   logic                  full;
   logic [7:0]            qry_q;
   logic [SCORE_BITS-1:0] col_q, left_old, cur_score;
   logic signed [SUM_BITS-1:0] diag_s, up_s, left_s, max_s;

   assign full             = (len_ff == LEN_BITS'(QUERY_MAX));
   assign stat.query_empty = (len_ff == '0);
   assign stat.last_row    = ({1'b0, row_ff} == len_ff - LEN_BITS'(1));
   assign stat.pipe_busy   = v1_ff || v2_ff;

   lase_ram #(.WIDTH(8), .DEPTH(QUERY_MAX)) u_query (
      .clock      (clock),
      .write_en   (cmd.append && !full),
      .write_addr (len_ff[ROW_BITS-1:0]),
      .write_data (req_symbol),
      .read_addr  (row_ff),
      .read_data  (qry_q)
   );

   lase_ram #(.WIDTH(SCORE_BITS), .DEPTH(QUERY_MAX)) u_column (
      .clock      (clock),
      .write_en   (v1_ff),
      .write_addr (row1_ff),
      .write_data (cur_score),
      .read_addr  (row_ff),
      .read_data  (col_q)
   );

   // cell score: max of diagonal, up, left and zero, saturated
   always_comb begin
      left_old = vbit_ff ? col_q : '0;
      if (qry_q == sym_ff) diag_s = $signed({2'b00, diag_ff}) + $signed(SUM_BITS'(match_ff));
      else diag_s = $signed({2'b00, diag_ff}) - $signed(SUM_BITS'(mismatch_ff));
      up_s   = $signed({2'b00, up_ff}) - $signed(SUM_BITS'(gap_ff));
      left_s = $signed({2'b00, left_old}) - $signed(SUM_BITS'(gap_ff));
      max_s  = diag_s;
      if (up_s > max_s) max_s = up_s;
      if (left_s > max_s) max_s = left_s;
      if (max_s < 0) cur_score = '0;
      else if (max_s > $signed({2'b00, SCORE_MAX})) cur_score = SCORE_MAX;
      else cur_score = max_s[SCORE_BITS-1:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         colcnt_ff <= '0;
         row_ff    <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         cvalid_ff <= '0;
         top_ff    <= '0;
         topcol_ff <= '0;
         toprow_ff <= '0;
         tie_ff    <= '0;
         peak_ff   <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         if (cmd.accept) begin
            peak_ff <= '0;
            ovf_ff  <= cmd.append && full;
         end
         if (cmd.clear) begin
            len_ff    <= '0;
            colcnt_ff <= '0;
            cvalid_ff <= '0;
            top_ff    <= '0;
            topcol_ff <= '0;
            toprow_ff <= '0;
            tie_ff    <= '0;
         end
         if (cmd.append && !full) len_ff <= len_ff + LEN_BITS'(1);
         if (cmd.col_start) begin
            row_ff <= '0;
            if (colcnt_ff != CNT_MAX) colcnt_ff <= colcnt_ff + CNT_BITS'(1);
         end
         if (cmd.issue) row_ff <= row_ff + ROW_BITS'(1);
         if (v1_ff) cvalid_ff[row1_ff] <= 1'b1;
         // tracking stage
         if (v2_ff) begin
            if (s2_ff > peak_ff) peak_ff <= s2_ff;
            if (s2_ff != '0) begin
               if (s2_ff > top_ff) begin
                  top_ff    <= s2_ff;
                  topcol_ff <= colcnt_ff;
                  toprow_ff <= {1'b0, row2_ff} + LEN_BITS'(1);
                  tie_ff    <= CNT_BITS'(1);
               end else if (s2_ff == top_ff && tie_ff != CNT_MAX) begin
                  tie_ff <= tie_ff + CNT_BITS'(1);
               end
            end
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (cmd.col_start) begin
         sym_ff  <= req_symbol;
         up_ff   <= '0;
         diag_ff <= '0;
      end
      if (cmd.issue) begin
         row1_ff <= row_ff;
         vbit_ff <= cvalid_ff[row_ff];
      end
      if (v1_ff) begin
         up_ff   <= cur_score;
         diag_ff <= left_old;
         s2_ff   <= cur_score;
         row2_ff <= row1_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         best_score     <= 16'(top_ff);
         best_column    <= 16'(topcol_ff);
         best_row       <= 9'(toprow_ff);
         best_tie_count <= 16'(tie_ff);
         column_peak    <= 16'(peak_ff);
         query_length   <= 9'(len_ff);
         query_overflow <= ovf_ff;
      end
   end
endmodule

// ===== rtl/core/local_alignment_score_engine_core.sv =====
// Channel  Dir  Handshake       Payload
// req_chan in   valid/ready     command, symbol
// rsp_chan out  valid/ready     best_score .. query_overflow
// csr_*    in   write enable    csr_index, csr_write_data
//
// Clear, append, unused and empty-query score items pass from accept to the
// done state; once the output is free the response is loaded and made valid,
// and the next item is taken as it turns valid. A score item reads one query
// row per cycle through the store read ports, drains the cell and tracking
// stages, then loads the response. Reset is synchronous and restores
// registers to 1 and all tracking to zero. A response held by rsp ready low
// blocks the next item only once its own result is ready.
// Depends on lase_pkg, lase_if, lase_ctrl, lase_dp, lase_ram.
`timescale 1ns / 1ps
module local_alignment_score_engine_core (
   input  logic       clock,
   input  logic       reset,
   lase_req_if.sink   req_chan,
   lase_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);
   import lase_pkg::*;

   lase_cmd_type  cmd;
   lase_stat_type stat;

   lase_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_command (req_chan.command),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .cmd         (cmd),
      .stat        (stat)
   );

   lase_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_symbol       (req_chan.symbol),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .best_score       (rsp_chan.best_score),
      .best_column      (rsp_chan.best_column),
      .best_row         (rsp_chan.best_row),
      .best_tie_count   (rsp_chan.best_tie_count),
      .column_peak      (rsp_chan.column_peak),
      .query_length     (rsp_chan.query_length),
      .query_overflow   (rsp_chan.query_overflow)
   );
endmodule

// ===== rtl/core/lase_checker.sv =====
// Port-level checks on the alignment engine, bound to the top level.
// Depends on lase_pkg and local_alignment_score_engine_core.
`timescale 1ns / 1ps
module lase_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] best_score,
   input logic [15:0] best_column,
   input logic [8:0]  best_row,
   input logic [15:0] best_tie_count,
   input logic [8:0]  query_length,
   input logic        query_overflow
);
   import lase_pkg::*;

   // response item holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(best_score))
      else $error("response dropped or changed while stalled");

   // overflow only with a full query store
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && query_overflow |-> query_length == 9'(QUERY_MAX))
      else $error("overflow without full query");

   // a zero best score carries no position and no ties
   a_zero_best: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && best_score == '0 |->
         best_column == '0 && best_row == '0 && best_tie_count == '0)
      else $error("zero best score with position or ties");

   // a nonzero best score has a cell and at least one tie
   a_best_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && best_score != '0 |->
         best_tie_count != '0 && best_row != '0 && best_column != '0)
      else $error("best score without position");
endmodule

bind local_alignment_score_engine_core lase_checker u_lase_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .best_score     (rsp_chan.best_score),
   .best_column    (rsp_chan.best_column),
   .best_row       (rsp_chan.best_row),
   .best_tie_count (rsp_chan.best_tie_count),
   .query_length   (rsp_chan.query_length),
   .query_overflow (rsp_chan.query_overflow)
);

// ===== verif/tb_local_alignment_score_engine_core.sv =====
// Testbench for local_alignment_score_engine_core: drives items and register
// writes, predicts each result and checks it. Depends on all of rtl/core.
`timescale 1ns / 1ps
module tb_local_alignment_score_engine_core;
   import lase_pkg::*;

   typedef struct packed {
      logic [15:0] best_score;
      logic [15:0] best_column;
      logic [8:0]  best_row;
      logic [15:0] best_tie_count;
      logic [15:0] column_peak;
      logic [8:0]  query_length;
      logic        query_overflow;
   } score_result_t;

   localparam int SAT_MAX = 65535;

   // alignment predictor plus the queue of results it expects
   class score_board;
      bit [7:0]      match_amt, mism_amt, gap_amt;
      bit [7:0]      query_mem [QUERY_MAX];
      int            col_mem [QUERY_MAX];
      int            qlen, colpos, top, top_col, top_row, ties;
      score_result_t pending [$];
      int            errors;

      function void clear_track();
         foreach (col_mem[i]) col_mem[i] = 0;
         qlen = 0; colpos = 0; top = 0; top_col = 0; top_row = 0; ties = 0;
      endfunction

      function void restart();
         match_amt = 1; mism_amt = 1; gap_amt = 1;
         errors = 0;
         clear_track();
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] val);
         case (idx)
            CSR_MATCH:    match_amt = val;
            CSR_MISMATCH: mism_amt = val;
            CSR_GAP:      gap_amt = val;
            default: ;
         endcase
      endfunction

      // one accepted item: update state and queue the result it produces
      function void note_item(logic [1:0] cmd, logic [7:0] sym);
         score_result_t r;
         int peak, ovf, diag_prev, up_new, left_old, diag, up, left, score;
         peak = 0; ovf = 0;
         case (cmd)
            CMD_CLEAR: clear_track();
            CMD_APPEND: begin
               if (qlen < QUERY_MAX) begin
                  query_mem[qlen] = sym;
                  qlen++;
               end else ovf = 1;
            end
            CMD_SCORE: begin
               diag_prev = 0; up_new = 0;
               if (colpos < SAT_MAX) colpos++;
               for (int row = 0; row < qlen; row++) begin
                  left_old = col_mem[row];
                  diag = (query_mem[row] == sym) ? diag_prev + int'(match_amt)
                                                 : diag_prev - int'(mism_amt);
                  up = up_new - int'(gap_amt);
                  left = left_old - int'(gap_amt);
                  score = 0;
                  if (diag > score) score = diag;
                  if (up > score) score = up;
                  if (left > score) score = left;
                  if (score > SAT_MAX) score = SAT_MAX;
                  col_mem[row] = score;
                  diag_prev = left_old;
                  up_new = score;
                  if (score > peak) peak = score;
                  if (score != 0) begin
                     if (score > top) begin
                        top = score; top_col = colpos; top_row = row + 1; ties = 1;
                     end else if (score == top && ties < SAT_MAX) ties++;
                  end
               end
            end
            default: ;
         endcase
         r.best_score = 16'(top);
         r.best_column = 16'(top_col);
         r.best_row = 9'(top_row);
         r.best_tie_count = 16'(ties);
         r.column_peak = 16'(peak);
         r.query_length = 9'(qlen);
         r.query_overflow = 1'(ovf);
         pending.push_back(r);
      endfunction

      function void check_result(score_result_t got);
         score_result_t want;
         if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.best_score !== want.best_score) begin
            $error("best_score exp %0d got %0d", want.best_score, got.best_score); errors++;
         end
         if (got.best_column !== want.best_column) begin
            $error("best_column exp %0d got %0d", want.best_column, got.best_column);
            errors++;
         end
         if (got.best_row !== want.best_row) begin
            $error("best_row exp %0d got %0d", want.best_row, got.best_row); errors++;
         end
         if (got.best_tie_count !== want.best_tie_count) begin
            $error("best_tie_count exp %0d got %0d", want.best_tie_count,
                   got.best_tie_count);
            errors++;
         end
         if (got.column_peak !== want.column_peak) begin
            $error("column_peak exp %0d got %0d", want.column_peak, got.column_peak);
            errors++;
         end
         if (got.query_length !== want.query_length) begin
            $error("query_length exp %0d got %0d", want.query_length, got.query_length);
            errors++;
         end
         if (got.query_overflow !== want.query_overflow) begin
            $error("query_overflow exp %0d got %0d", want.query_overflow,
                   got.query_overflow);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;
   int         idle_pct;
   int         stall_pct;
   score_board sb;

   lase_req_if req_chan ();
   lase_rsp_if rsp_chan ();

   local_alignment_score_engine_core DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   initial begin
      clock = 0;
      reset = 1;
      req_chan.valid = 0;
      req_chan.command = CMD_CLEAR;
      req_chan.symbol = 0;
      rsp_chan.ready = 0;
      csr_write_enable = 0;
      csr_index = CSR_MATCH;
      csr_write_data = 0;
      idle_pct = 0;
      stall_pct = 0;
      sb = new();
      sb.restart();
   end

   // result side: check accepted results, stall at random
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result({rsp_chan.best_score, rsp_chan.best_column, rsp_chan.best_row,
                             rsp_chan.best_tie_count, rsp_chan.column_peak,
                             rsp_chan.query_length, rsp_chan.query_overflow});
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // offer one item, with random idle cycles ahead of it
   task automatic send_item(logic [1:0] cmd, logic [7:0] sym);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.command <= cmd;
      req_chan.symbol <= sym;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_item(cmd, sym);
   endtask

   // register write once the block has drained
   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      req_chan.valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.set_reg(idx, val);
   endtask

   task automatic set_phase(int p);
      case (p)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 69; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 69; end
         default: begin idle_pct = 38; stall_pct = 38; end
      endcase
   endtask

   // pick from a small alphabet mostly so matches are common
   function automatic logic [7:0] pick_sym();
      return ($urandom_range(9) < 8) ? 8'($urandom_range(3)) : 8'($urandom);
   endfunction

   // stimulus
   initial begin
      int sent, qn, cn;
      logic [7:0] val;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, every command, empty query, idle command
      send_item(CMD_SCORE, 8'h00);
      send_item(CMD_APPEND, 8'h00);
      send_item(CMD_APPEND, 8'hFF);
      send_item(CMD_APPEND, 8'hAA);
      send_item(CMD_APPEND, 8'h55);
      send_item(CMD_SCORE, 8'hFF);
      send_item(CMD_SCORE, 8'h00);
      send_item(CMD_SCORE, 8'h55);
      send_item(CMD_NOP, 8'hFF);
      send_item(CMD_CLEAR, 8'hFF);
      write_reg(CSR_MATCH, 8'hFF);
      write_reg(CSR_MISMATCH, 8'h00);
      write_reg(CSR_GAP, 8'h00);
      for (int i = 0; i < 4; i++) send_item(CMD_APPEND, 8'(i));
      for (int i = 0; i < 4; i++) send_item(CMD_SCORE, 8'(i));
      write_reg(CSR_MISMATCH, 8'hFF);
      write_reg(CSR_GAP, 8'hFF);
      send_item(CMD_SCORE, 8'h07);
      send_item(CMD_SCORE, 8'h02);

      // full query, then an append that overflows; max diagonal growth
      send_item(CMD_CLEAR, 8'h00);
      for (int i = 0; i <= QUERY_MAX; i++) send_item(CMD_APPEND, 8'h11);
      send_item(CMD_SCORE, 8'h11);
      send_item(CMD_SCORE, 8'h11);

      // tie count saturation: every cell scores one
      write_reg(CSR_MATCH, 8'd1);
      write_reg(CSR_MISMATCH, 8'd0);
      write_reg(CSR_GAP, 8'd0);
      send_item(CMD_CLEAR, 8'h00);
      send_item(CMD_APPEND, 8'h05);
      for (int i = 1; i < QUERY_MAX; i++) send_item(CMD_APPEND, 8'h00);
      for (int i = 0; i < QUERY_MAX + 2; i++) send_item(CMD_SCORE, 8'h05);

      // random part: mostly clear, load, score sequences
      write_reg(CSR_GAP, 8'd1);
      sent = 0;
      while (sent < 500) begin
         if ($urandom_range(5) == 0) set_phase($urandom_range(3));
         if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
               0: val = 8'h00;
               1: val = 8'hFF;
               default: val = 8'($urandom_range(6));
            endcase
            write_reg(2'($urandom_range(2)), val);
         end
         if ($urandom_range(99) < 85) begin
            send_item(CMD_CLEAR, 8'($urandom));
            qn = ($urandom_range(19) == 0) ? $urandom_range(200, QUERY_MAX + 2)
                                           : $urandom_range(1, 12);
            cn = (qn > 100) ? $urandom_range(1, 3) : $urandom_range(1, 20);
            for (int i = 0; i < qn; i++) send_item(CMD_APPEND, pick_sym());
            for (int i = 0; i < cn; i++) send_item(CMD_SCORE, pick_sym());
            sent += qn + cn + 1;
         end else begin
            for (int i = 0; i < 6; i++) send_item(2'($urandom_range(3)), 8'($urandom));
            sent += 6;
         end
      end
      req_chan.valid <= 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog
   initial begin
      #40000000;
      $display("status: fail");
      $finish;
   end
endmodule
